/* src/fsrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrf_pkg
// Shared types, constants and helpers of the four-state radix formatter.
// ----------------------------------------------------------------------------
package fsrf_pkg;

   // vector geometry
   localparam int MAX_WIDTH = 64;
   localparam int WIDTH_W   = 7;
   localparam int GROUP_W   = 4;
   localparam int DIGITS    = 20;
   localparam int BCD_W     = DIGITS * 4;
   localparam int ITER_W    = 5;
   localparam int DIG_CNT_W = 5;
   localparam int CHAR_W    = 7;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED_DECIMAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_WIDTH   = 2'd2;

   // ascii codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_HEX_BASE = 7'h57;
   localparam logic [CHAR_W-1:0] CHAR_X        = 7'h78;
   localparam logic [CHAR_W-1:0] CHAR_Z        = 7'h7a;
   localparam logic [CHAR_W-1:0] CHAR_MINUS    = 7'h2d;

   typedef enum logic [1:0] {
      RADIX_BIN = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2,
      RADIX_DEC = 2'd3
   } radix_type;

   typedef struct packed {
      logic [MAX_WIDTH-1:0] value_bits;
      logic [MAX_WIDTH-1:0] unknown_bits;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_char;
   } rsp_type;

   typedef struct packed {
      radix_type          radix_mode;
      logic               signed_decimal;
      logic [WIDTH_W-1:0] vector_width;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_GROUP,
      ST_XCHAR,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_START,
      CMD_GROUP,
      CMD_XCHAR,
      CMD_CONV,
      CMD_SKIP,
      CMD_SIGN,
      CMD_DIGIT
   } cmd_type;

   typedef struct packed {
      logic decimal_mode;
      logic any_unknown;
      logic neg;
      logic conv_done;
      logic group_last;
      logic top_zero;
      logic one_left;
      logic out_free;
   } status_type;

   // ascii digit for a nibble
   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
      logic [CHAR_W-1:0] base;
      base = (v < 4'd10) ? CHAR_ZERO : CHAR_HEX_BASE;
      return base + {3'b000, v};
   endfunction

endpackage

/* src/fsrf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrf_ctrl
// Sequencer: walks one transaction through load, digit groups, a lone 'x'
// or the decimal conversion, leading zero skip and character output.
// ----------------------------------------------------------------------------
module fsrf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fsrf_pkg::status_type status,
   output fsrf_pkg::cmd_type    cmd
);

   fsrf_pkg::state_type state_ff;
   fsrf_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsrf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsrf_pkg::ST_IDLE: begin
            if (req_valid) state_in = fsrf_pkg::ST_START;
         end
         fsrf_pkg::ST_START: begin
            priority if (!status.decimal_mode) state_in = fsrf_pkg::ST_GROUP;
            else if (status.any_unknown)       state_in = fsrf_pkg::ST_XCHAR;
            else                               state_in = fsrf_pkg::ST_CONV;
         end
         fsrf_pkg::ST_GROUP: begin
            if (status.out_free && status.group_last) state_in = fsrf_pkg::ST_IDLE;
         end
         fsrf_pkg::ST_XCHAR: begin
            if (status.out_free) state_in = fsrf_pkg::ST_IDLE;
         end
         fsrf_pkg::ST_CONV: begin
            if (status.conv_done) state_in = fsrf_pkg::ST_SKIP;
         end
         fsrf_pkg::ST_SKIP: begin
            if (!status.top_zero || status.one_left) begin
               state_in = status.neg ? fsrf_pkg::ST_SIGN : fsrf_pkg::ST_DIGIT;
            end
         end
         fsrf_pkg::ST_SIGN: begin
            if (status.out_free) state_in = fsrf_pkg::ST_DIGIT;
         end
         fsrf_pkg::ST_DIGIT: begin
            if (status.out_free && status.one_left) state_in = fsrf_pkg::ST_IDLE;
         end
         default: state_in = fsrf_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      cmd       = fsrf_pkg::CMD_NONE;
      unique case (state_ff)
         fsrf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd = fsrf_pkg::CMD_LOAD;
         end
         fsrf_pkg::ST_START: cmd = fsrf_pkg::CMD_START;
         fsrf_pkg::ST_GROUP: begin
            if (status.out_free) cmd = fsrf_pkg::CMD_GROUP;
         end
         fsrf_pkg::ST_XCHAR: begin
            if (status.out_free) cmd = fsrf_pkg::CMD_XCHAR;
         end
         fsrf_pkg::ST_CONV: cmd = fsrf_pkg::CMD_CONV;
         fsrf_pkg::ST_SKIP: begin
            if (status.top_zero && !status.one_left) cmd = fsrf_pkg::CMD_SKIP;
         end
         fsrf_pkg::ST_SIGN: begin
            if (status.out_free) cmd = fsrf_pkg::CMD_SIGN;
         end
         fsrf_pkg::ST_DIGIT: begin
            if (status.out_free) cmd = fsrf_pkg::CMD_DIGIT;
         end
         default: cmd = fsrf_pkg::CMD_NONE;
      endcase
   end

endmodule

/* src/fsrf_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrf_dpath
// Datapath: operand planes, digit group extraction, two-bit-per-cycle
// double dabble conversion and the registered result stage.
// ----------------------------------------------------------------------------
module fsrf_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  fsrf_pkg::cmd_type    cmd,
   input  fsrf_pkg::cfg_type    cfg,
   input  fsrf_pkg::req_type    req_data,
   input  logic                 rsp_stall,
   output fsrf_pkg::status_type status,
   output logic                 rsp_valid,
   output fsrf_pkg::rsp_type    rsp_data
);

   localparam int MW = fsrf_pkg::MAX_WIDTH;
   localparam int WW = fsrf_pkg::WIDTH_W;
   localparam int BW = fsrf_pkg::BCD_W;
   localparam int CW = BW + MW;

   // low bits set up to width w (w is 1..MAX_WIDTH)
   function automatic logic [MW-1:0] width_mask(input logic [WW-1:0] w);
      logic [WW-1:0] sh;
      sh = WW'(MW) - w;
      return {MW{1'b1}} >> sh;
   endfunction

   // one double dabble step: adjust every digit, then shift
   function automatic logic [CW-1:0] dd_step(input logic [CW-1:0] v);
      logic [CW-1:0] t;
      t = v;
      for (int i = 0; i < fsrf_pkg::DIGITS; i++) begin
         if (t[MW + 4*i +: 4] >= 4'd5) t[MW + 4*i +: 4] = t[MW + 4*i +: 4] + 4'd3;
      end
      return t << 1;
   endfunction

   logic [MW-1:0]                  a_ff, a_in;
   logic [MW-1:0]                  b_ff, b_in;
   logic [WW-1:0]                  w_ff, w_in;
   fsrf_pkg::radix_type            mode_ff, mode_in;
   logic                           sgn_ff, sgn_in;
   logic [WW-1:0]                  lo_ff, lo_in;
   logic                           neg_ff, neg_in;
   logic [MW-1:0]                  bin_ff, bin_in;
   logic [BW-1:0]                  bcd_ff, bcd_in;
   logic [fsrf_pkg::ITER_W-1:0]    iter_ff, iter_in;
   logic [fsrf_pkg::DIG_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   fsrf_pkg::rsp_type              rsp_ff, rsp_in;

   logic [2:0]                bpd;
   logic [WW-1:0]             wm1;
   logic [14:0]               recip_prod;
   logic [5:0]                oct_q;
   logic [WW-1:0]             lo_top;
   logic [MW-1:0]             mask;
   logic                      neg_now;
   logic [MW-1:0]             a_sh;
   logic [MW-1:0]             b_sh;
   logic [WW-1:0]             remain;
   logic [2:0]                cnt;
   logic [3:0]                gmask;
   logic [3:0]                ga;
   logic [3:0]                gb;
   logic [fsrf_pkg::CHAR_W-1:0] group_char;
   logic [CW-1:0]             dd_next;
   logic                      emit;

   // bits per digit of the grouped radixes
   always_comb begin
      unique case (mode_ff)
         fsrf_pkg::RADIX_BIN: bpd = 3'd1;
         fsrf_pkg::RADIX_OCT: bpd = 3'd3;
         fsrf_pkg::RADIX_HEX: bpd = 3'd4;
         fsrf_pkg::RADIX_DEC: bpd = 3'd4;
         default:             bpd = 3'd4;
      endcase
   end

   // position of the top group: floor((w-1)/bpd)*bpd, divide by 3 via 171/512
   always_comb begin
      wm1        = w_ff - WW'(1);
      recip_prod = {8'b0, wm1} * 15'd171;
      oct_q      = recip_prod[14:9];
      unique case (mode_ff)
         fsrf_pkg::RADIX_BIN: lo_top = wm1;
         fsrf_pkg::RADIX_OCT: lo_top = {oct_q, 1'b0} + {1'b0, oct_q};
         fsrf_pkg::RADIX_HEX: lo_top = {wm1[WW-1:2], 2'b00};
         fsrf_pkg::RADIX_DEC: lo_top = {wm1[WW-1:2], 2'b00};
         default:             lo_top = wm1;
      endcase
   end

   // sign of the value within the width
   always_comb begin
      mask    = width_mask(w_ff);
      neg_now = sgn_ff && a_ff[wm1[5:0]];
   end

   // current digit group
   always_comb begin
      a_sh   = a_ff >> lo_ff[5:0];
      b_sh   = b_ff >> lo_ff[5:0];
      remain = w_ff - lo_ff;
      cnt    = (remain < {4'b0, bpd}) ? remain[2:0] : bpd;
      gmask  = 4'((5'd1 << cnt) - 5'd1);
      ga     = a_sh[3:0] & gmask;
      gb     = b_sh[3:0] & gmask;
      priority if (gb == 4'd0)                 group_char = fsrf_pkg::hex_char(ga);
      else if (gb == gmask && ga == 4'd0)      group_char = fsrf_pkg::CHAR_Z;
      else                                     group_char = fsrf_pkg::CHAR_X;
   end

   // two conversion steps per cycle
   assign dd_next = dd_step(dd_step({bcd_ff, bin_ff}));

   // next values
   always_comb begin
      a_in       = a_ff;
      b_in       = b_ff;
      w_in       = w_ff;
      mode_in    = mode_ff;
      sgn_in     = sgn_ff;
      lo_in      = lo_ff;
      neg_in     = neg_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      iter_in    = iter_ff;
      dig_cnt_in = dig_cnt_ff;
      rsp_in     = rsp_ff;
      emit       = 1'b0;
      unique case (cmd)
         fsrf_pkg::CMD_NONE: begin
         end
         fsrf_pkg::CMD_LOAD: begin
            a_in    = req_data.value_bits & width_mask(cfg.vector_width);
            b_in    = req_data.unknown_bits & width_mask(cfg.vector_width);
            w_in    = cfg.vector_width;
            mode_in = cfg.radix_mode;
            sgn_in  = cfg.signed_decimal;
         end
         fsrf_pkg::CMD_START: begin
            lo_in      = lo_top;
            neg_in     = neg_now;
            bin_in     = neg_now ? ((~a_ff + MW'(1)) & mask) : a_ff;
            bcd_in     = '0;
            iter_in    = '0;
            dig_cnt_in = fsrf_pkg::DIG_CNT_W'(fsrf_pkg::DIGITS);
         end
         fsrf_pkg::CMD_GROUP: begin
            emit   = 1'b1;
            rsp_in = '{digit_char: group_char, last_char: (lo_ff == '0)};
            lo_in  = lo_ff - {4'b0, bpd};
         end
         fsrf_pkg::CMD_XCHAR: begin
            emit   = 1'b1;
            rsp_in = '{digit_char: fsrf_pkg::CHAR_X, last_char: 1'b1};
         end
         fsrf_pkg::CMD_CONV: begin
            {bcd_in, bin_in} = dd_next;
            iter_in          = iter_ff + fsrf_pkg::ITER_W'(1);
         end
         fsrf_pkg::CMD_SKIP: begin
            bcd_in     = bcd_ff << 4;
            dig_cnt_in = dig_cnt_ff - fsrf_pkg::DIG_CNT_W'(1);
         end
         fsrf_pkg::CMD_SIGN: begin
            emit   = 1'b1;
            rsp_in = '{digit_char: fsrf_pkg::CHAR_MINUS, last_char: 1'b0};
         end
         fsrf_pkg::CMD_DIGIT: begin
            emit       = 1'b1;
            rsp_in     = '{digit_char: fsrf_pkg::CHAR_ZERO + {3'b000, bcd_ff[BW-1 -: 4]},
                           last_char:  (dig_cnt_ff == fsrf_pkg::DIG_CNT_W'(1))};
            bcd_in     = bcd_ff << 4;
            dig_cnt_in = dig_cnt_ff - fsrf_pkg::DIG_CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // result stage valid
   always_comb begin
      priority if (emit)  rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else                rsp_valid_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
         dig_cnt_ff   <= '0;
         lo_ff        <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
         dig_cnt_ff   <= dig_cnt_in;
         lo_ff        <= lo_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      w_ff    <= w_in;
      mode_ff <= mode_in;
      sgn_ff  <= sgn_in;
      neg_ff  <= neg_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      rsp_ff  <= rsp_in;
   end

   // status to the sequencer
   always_comb begin
      status.decimal_mode = (mode_ff == fsrf_pkg::RADIX_DEC);
      status.any_unknown  = |b_ff;
      status.neg          = neg_ff;
      status.conv_done    = (iter_ff == {fsrf_pkg::ITER_W{1'b1}});
      status.group_last   = (lo_ff == '0);
      status.top_zero     = (bcd_ff[BW-1 -: 4] == 4'd0);
      status.one_left     = (dig_cnt_ff == fsrf_pkg::DIG_CNT_W'(1));
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/four_state_radix_formatter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_state_radix_formatter
// Prints a four-state vector of up to 64 bits as ASCII text, one character
// per response transaction, most significant character first.
// ----------------------------------------------------------------------------
// Usage: a request transaction carries the value and unknown bit planes; the
// block answers with the characters of its text, the final one flagged by
// last_char. Radix, signedness and width come from the csr write port, which
// is always ready and must only be written while no request is in flight.
// Binary, octal and hex: a start step, then one character per cycle while
// the response is not stalled. Decimal: a start step, double dabble
// conversion at two bits per cycle, a skip of the leading zero digits,
// then the characters including the sign. In decimal, a vector with an
// unknown bit prints a lone 'x' instead. The next request is taken once
// the last character sits in the response register. A response stall
// holds the current character and pauses the sequencer in its character
// output states. Reset returns the registers to hex, unsigned, width 64
// and drops any transaction in progress.
// ----------------------------------------------------------------------------
module four_state_radix_formatter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  fsrf_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output fsrf_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fsrf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fsrf_pkg::WIDTH_W-1:0]       csr_wdata
);

   fsrf_pkg::cfg_type    cfg_ff, cfg_in;
   fsrf_pkg::status_type status;
   fsrf_pkg::cmd_type    cmd;
   logic [fsrf_pkg::WIDTH_W-1:0] width_clamped;

   assign csr_ready = 1'b1;

   // width is kept within 1..MAX_WIDTH
   always_comb begin
      priority if (csr_wdata == '0)
         width_clamped = fsrf_pkg::WIDTH_W'(1);
      else if (csr_wdata > fsrf_pkg::WIDTH_W'(fsrf_pkg::MAX_WIDTH))
         width_clamped = fsrf_pkg::WIDTH_W'(fsrf_pkg::MAX_WIDTH);
      else
         width_clamped = csr_wdata;
   end

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fsrf_pkg::CSR_RADIX_MODE:
               cfg_in.radix_mode = fsrf_pkg::radix_type'(csr_wdata[1:0]);
            fsrf_pkg::CSR_SIGNED_DECIMAL: cfg_in.signed_decimal = csr_wdata[0];
            fsrf_pkg::CSR_VECTOR_WIDTH:   cfg_in.vector_width   = width_clamped;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radix_mode     <= fsrf_pkg::RADIX_HEX;
         cfg_ff.signed_decimal <= 1'b0;
         cfg_ff.vector_width   <= fsrf_pkg::WIDTH_W'(fsrf_pkg::MAX_WIDTH);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   fsrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   fsrf_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/fsrf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrf_checker
// Port-level checks of the four-state radix formatter, bound to the top.
// ----------------------------------------------------------------------------
module fsrf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input fsrf_pkg::rsp_type              rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // an accepted request closes the request side while it is worked on
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side open right after a transaction");

   // a minus sign is never the final character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.digit_char == fsrf_pkg::CHAR_MINUS |-> !rsp_data.last_char)
      else $error("text ends in a sign");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind four_state_radix_formatter fsrf_checker u_fsrf_checker (.*);
